// ----- hw/rtl/rbvb_pkg.sv -----
// Shared types and constants of the radial brush vertex blend block.
// Used by the top level and the testbench; depends on nothing.
package rbvb_pkg;

  // Default geometry of the grid and of the brush coordinates.
  localparam int MaxColumnsDef   = 64;
  localparam int MaxRowsDef      = 64;
  localparam int FractionBitsDef = 8;

  // Width of the signed cell coordinates used inside the paint walk.
  localparam int CoordW = 16;

  // One corner color is RGBA, and one memory word holds the four corners of a cell.
  localparam int ColorW  = 32;
  localparam int Corners = 4;
  localparam int WordW   = ColorW * Corners;

  localparam logic [6:0] GridReset = 7'd64;

  typedef enum logic [1:0] {
    ActSet   = 2'd0,
    ActPaint = 2'd1,
    ActRead  = 2'd2,
    ActNone  = 2'd3
  } action_e;

  typedef enum logic {
    CfgColumns = 1'b0,
    CfgRows    = 1'b1
  } cfg_index_e;

endpackage

// ----- hw/rtl/rbvb_isqrt.sv -----
// Iterative integer square root, one result bit per cycle.
// Used by radial_brush_vertex_blend; no package dependency.
module rbvb_isqrt #(
  parameter int FRACTION_BITS = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [2*FRACTION_BITS-1:0]   radicand_i,
  output logic                         done_o,
  output logic [FRACTION_BITS-1:0]     root_o
);

  localparam int F   = FRACTION_BITS;
  localparam int SqW = $clog2(FRACTION_BITS);

  logic           busy_q;
  logic           done_q;
  logic [SqW-1:0] cnt_q;
  logic [2*F-1:0] v_q;
  logic [F+1:0]   rem_q;
  logic [F-1:0]   root_q;

  logic [F+3:0]   rem_shift;
  logic [F+3:0]   trial;
  logic           fits;

  assign rem_shift = {rem_q, v_q[2*F-1:2*F-2]};
  assign trial     = (F+4)'({root_q, 2'b01});
  assign fits      = rem_shift >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= SqW'(F - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - SqW'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q    <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      v_q <= {v_q[2*F-3:0], 2'b00};
      if (fits) begin
        rem_q  <= (F+2)'(rem_shift - trial);
        root_q <= {root_q[F-2:0], 1'b1};
      end else begin
        rem_q  <= rem_shift[F+1:0];
        root_q <= {root_q[F-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ----- hw/rtl/radial_brush_vertex_blend.sv -----
// Top level of the radial brush vertex blend block: corner color memory,
// request sequencer and the shared multiplier. Uses rbvb_pkg and rbvb_isqrt.
//
// The block holds a grid of MAX_COLUMNS x MAX_ROWS cells, each with four corner
// colors kept together in one 128-bit memory word. After reset a clearing pass
// writes opaque white into every word, one word per cycle, so the block takes no
// request until the pass is done; configuration writes are taken throughout. A
// set request writes all four corners of a cell inside the grid in the cycle it
// is accepted; its result then goes through the done state into the output
// register, and the next request can be taken once that has happened. A read
// request passes through S_READ and S_RDOUT because of the registered memory
// read. A paint request walks the 3x3 cells around the brush through one
// sequencer: for each cell in use the shared multiplier gives the squared
// distance of each corner, and each corner within the brush radius then takes
// the bit-serial square root, the weight, three channel blends and the write
// back. At most two grid points lie within the radius, and each is a corner of
// up to four cells, so at most eight corners are blended. The block works on
// one request at a time and holds in_stall_o high until its result has moved
// into the output register; a finished result waits there, and the next
// request is accepted meanwhile.
module radial_brush_vertex_blend #(
  parameter int MAX_COLUMNS   = rbvb_pkg::MaxColumnsDef,
  parameter int MAX_ROWS      = rbvb_pkg::MaxRowsDef,
  parameter int FRACTION_BITS = rbvb_pkg::FractionBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration writes.
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [6:0]  cfg_data_i,
  // Request channel.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [5:0]  cell_x_i,
  input  logic [5:0]  cell_y_i,
  input  logic [1:0]  corner_i,
  input  logic [13:0] brush_x_i,
  input  logic [13:0] brush_y_i,
  input  logic [7:0]  paint_red_i,
  input  logic [7:0]  paint_green_i,
  input  logic [7:0]  paint_blue_i,
  input  logic [7:0]  paint_alpha_i,
  // Result channel.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_red_o,
  output logic [7:0]  out_green_o,
  output logic [7:0]  out_blue_o,
  output logic [7:0]  out_alpha_o,
  output logic        out_of_range_o
);

  localparam int F     = FRACTION_BITS;
  localparam int CW    = $clog2(MAX_COLUMNS);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int Depth = MAX_COLUMNS * MAX_ROWS;
  localparam int AW    = $clog2(Depth);
  localparam int CrdW  = rbvb_pkg::CoordW;
  localparam int WW    = rbvb_pkg::WordW;
  localparam int MW    = F + 9;
  localparam int PW    = 2 * MW;
  localparam int DXW   = F + 3;
  localparam int D2W   = 2 * F + 4;
  localparam int SW    = CrdW + F + 1;

  localparam logic [D2W-1:0] D2Limit = D2W'(1) << (2 * F - 1);
  localparam logic [F+7:0]   DenVal  = (F+8)'(255) << F;
  localparam logic [F:0]     OneQ    = (F+1)'(1) << F;

  typedef enum logic [13:0] {
    S_CLEAR = 14'b00000000000001,
    S_IDLE  = 14'b00000000000010,
    S_READ  = 14'b00000000000100,
    S_RDOUT = 14'b00000000001000,
    S_CELL  = 14'b00000000010000,
    S_DX    = 14'b00000000100000,
    S_DY    = 14'b00000001000000,
    S_CMP   = 14'b00000010000000,
    S_SQRT  = 14'b00000100000000,
    S_K     = 14'b00001000000000,
    S_CH    = 14'b00010000000000,
    S_ACC   = 14'b00100000000000,
    S_WB    = 14'b01000000000000,
    S_DONE  = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [6:0] cols_q, rows_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= rbvb_pkg::GridReset;
      rows_q <= rbvb_pkg::GridReset;
    end else if (cfg_we_i) begin
      unique case (rbvb_pkg::cfg_index_e'(cfg_index_i))
        rbvb_pkg::CfgColumns: cols_q <= cfg_data_i;
        rbvb_pkg::CfgRows:    rows_q <= cfg_data_i;
        default:              cols_q <= cols_q;
      endcase
    end
  end

  // Register values above the grid size count as the grid size.
  logic [CrdW-1:0] cols_eff, rows_eff;
  assign cols_eff = (CrdW'(cols_q) > CrdW'(MAX_COLUMNS)) ? CrdW'(MAX_COLUMNS) : CrdW'(cols_q);
  assign rows_eff = (CrdW'(rows_q) > CrdW'(MAX_ROWS)) ? CrdW'(MAX_ROWS) : CrdW'(rows_q);

  function automatic logic [AW-1:0] cell_addr(input logic [CrdW-1:0] xc,
                                               input logic [CrdW-1:0] yc);
    cell_addr = AW'(yc[RW-1:0]) * AW'(MAX_COLUMNS) + AW'(xc[CW-1:0]);
  endfunction

  // Request decode.
  logic                  in_accept;
  rbvb_pkg::action_e     act;
  logic                  in_inside;
  logic [AW-1:0]         in_addr;
  logic [rbvb_pkg::ColorW-1:0] in_color;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign act        = rbvb_pkg::action_e'(action_i);
  assign in_inside  = (CrdW'(cell_x_i) < cols_eff) && (CrdW'(cell_y_i) < rows_eff);
  assign in_addr    = cell_addr(CrdW'(cell_x_i), CrdW'(cell_y_i));
  assign in_color   = {paint_red_i, paint_green_i, paint_blue_i, paint_alpha_i};

  // Paint walk state.
  logic [CrdW-1:0] cx_q, cy_q;
  logic [13:0]     bx_q, by_q;
  logic [7:0]      pr_q, pg_q, pb_q, alpha_q;
  logic [1:0]      i_q, j_q, c_q, ch_q;
  logic [AW-1:0]   addr_q;
  logic [AW-1:0]   clr_q;
  logic [WW-1:0]   rdata_q;

  logic signed [CrdW-1:0] cell_xs, cell_ys;
  logic                   cell_skip;
  logic                   last_cell;

  assign cell_xs   = signed'(cx_q + CrdW'(i_q) - CrdW'(1));
  assign cell_ys   = signed'(cy_q + CrdW'(j_q) - CrdW'(1));
  assign cell_skip = cell_xs[CrdW-1] || cell_ys[CrdW-1] ||
                     (cell_xs >= signed'(cols_eff)) || (cell_ys >= signed'(rows_eff));
  assign last_cell = (i_q == 2'd2) && (j_q == 2'd2);

  // Corner position minus brush position, in the brush's fixed point format.
  logic                   off_x, off_y;
  logic [CrdW-1:0]        corner_x, corner_y;
  logic signed [SW-1:0]   dx_w, dy_w;
  logic signed [DXW-1:0]  dx_s, dy_s;

  assign off_x    = (c_q == 2'd1) || (c_q == 2'd2);
  assign off_y    = c_q[1];
  assign corner_x = cell_xs + CrdW'(off_x);
  assign corner_y = cell_ys + CrdW'(off_y);
  assign dx_w     = (SW'(signed'(corner_x)) <<< F) - signed'(SW'(bx_q));
  assign dy_w     = (SW'(signed'(corner_y)) <<< F) - signed'(SW'(by_q));
  assign dx_s     = dx_w[DXW-1:0];
  assign dy_s     = dy_w[DXW-1:0];

  // Blend of one channel: old*D + (paint-old)*k, then divided by 255*2^F.
  logic [6:0]           obase;
  logic [7:0]           old_ch, new_ch;
  logic signed [8:0]    diff;
  logic signed [PW-1:0] prod_q;
  logic signed [PW-1:0] num;
  logic [15:0]          quo;
  logic [16:0]          nsum;
  logic [7:0]           ch_byte;

  assign obase  = {c_q, 5'b0} + 7'd24 - {2'b0, ch_q, 3'b0};
  assign old_ch = rdata_q[obase +: 8];

  always_comb begin
    unique case (ch_q)
      2'd0:    new_ch = pr_q;
      2'd1:    new_ch = pg_q;
      default: new_ch = pb_q;
    endcase
  end

  assign diff    = signed'({1'b0, new_ch}) - signed'({1'b0, old_ch});
  assign num     = signed'(((PW'(old_ch) << 8) - PW'(old_ch)) << F) + prod_q;
  assign quo     = num[F+15:F];
  // Exact floor(quo/255) for quo below 2^16 - 1.
  assign nsum    = 17'(quo) + 17'(quo >> 8) + 17'd1;
  assign ch_byte = nsum[15:8];

  // Shared multiplier.
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] mul_p;
  logic [D2W-1:0]       d2_q;
  logic [F:0]           w_q;
  logic [F+7:0]         k_q;

  always_comb begin
    mul_a = MW'(dx_s);
    mul_b = MW'(dx_s);
    unique case (state_q)
      S_DY: begin
        mul_a = MW'(dy_s);
        mul_b = MW'(dy_s);
      end
      S_K: begin
        mul_a = signed'(MW'(w_q));
        mul_b = signed'(MW'(alpha_q));
      end
      S_CH: begin
        mul_a = MW'(diff);
        mul_b = signed'(MW'(k_q));
      end
      default: begin
        mul_a = MW'(dx_s);
        mul_b = MW'(dx_s);
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Square root of twice the squared distance gives the distance over the radius.
  logic           sq_start, sq_done;
  logic [F-1:0]   sq_root;
  logic [2*F-1:0] sq_rad;

  assign sq_start = (state_q == S_CMP) && (d2_q < D2Limit);
  assign sq_rad   = {d2_q[2*F-2:0], 1'b0};

  rbvb_isqrt #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_isqrt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (sq_start),
    .radicand_i(sq_rad),
    .done_o    (sq_done),
    .root_o    (sq_root)
  );

  // New colors of the corner being painted.
  logic [7:0]    newc_q [3];
  logic [WW-1:0] wb_word;

  always_comb begin
    wb_word = rdata_q;
    wb_word[{c_q, 5'b0} +: rbvb_pkg::ColorW] = {newc_q[0], newc_q[1], newc_q[2], 8'hFF};
  end

  // Corner color memory: one word per cell, one write and one read port.
  logic [WW-1:0] mem [Depth];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [WW-1:0] mem_wdata;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = in_addr;
    mem_wdata = {rbvb_pkg::Corners{in_color}};
    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '1;
      end
      S_WB: begin
        mem_we    = 1'b1;
        mem_waddr = addr_q;
        mem_wdata = wb_word;
      end
      S_IDLE: begin
        mem_we = in_accept && (act == rbvb_pkg::ActSet) && in_inside;
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[addr_q];
  end

  // Result held until the output register is free.
  logic [rbvb_pkg::ColorW-1:0] res_color_q;
  logic                        res_oor_q;
  logic                        out_valid_q;
  logic [rbvb_pkg::ColorW-1:0] out_color_q;
  logic                        out_oor_q;
  logic                        out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (clr_q == AW'(Depth - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_accept) begin
          unique case (act)
            rbvb_pkg::ActPaint: state_d = S_CELL;
            rbvb_pkg::ActRead:  state_d = in_inside ? S_READ : S_DONE;
            default:            state_d = S_DONE;
          endcase
        end
      end
      S_READ:  state_d = S_RDOUT;
      S_RDOUT: state_d = S_DONE;
      S_CELL: begin
        if (!cell_skip)     state_d = S_DX;
        else if (last_cell) state_d = S_DONE;
      end
      S_DX: state_d = S_DY;
      S_DY: state_d = S_CMP;
      S_CMP: begin
        if (sq_start)                    state_d = S_SQRT;
        else if (c_q != 2'd3)            state_d = S_DX;
        else                             state_d = last_cell ? S_DONE : S_CELL;
      end
      S_SQRT: begin
        if (sq_done) state_d = S_K;
      end
      S_K:   state_d = S_CH;
      S_CH:  state_d = S_ACC;
      S_ACC: state_d = (ch_q == 2'd2) ? S_WB : S_CH;
      S_WB: begin
        if (c_q != 2'd3) state_d = S_DX;
        else             state_d = last_cell ? S_DONE : S_CELL;
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
      if ((state_q == S_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers of the sequencer.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          addr_q      <= in_addr;
          c_q         <= corner_i;
          cx_q        <= CrdW'(brush_x_i >> F);
          cy_q        <= CrdW'(brush_y_i >> F);
          bx_q        <= brush_x_i;
          by_q        <= brush_y_i;
          pr_q        <= paint_red_i;
          pg_q        <= paint_green_i;
          pb_q        <= paint_blue_i;
          alpha_q     <= paint_alpha_i;
          i_q         <= 2'd0;
          j_q         <= 2'd0;
          res_color_q <= '0;
          res_oor_q   <= ((act == rbvb_pkg::ActSet) || (act == rbvb_pkg::ActRead)) &&
                         !in_inside;
        end
      end
      S_RDOUT: res_color_q <= rdata_q[{c_q, 5'b0} +: rbvb_pkg::ColorW];
      S_CELL: begin
        if (!cell_skip) begin
          addr_q <= cell_addr(cell_xs, cell_ys);
          c_q    <= 2'd0;
        end else if (i_q != 2'd2) begin
          i_q <= i_q + 2'd1;
        end else begin
          i_q <= 2'd0;
          j_q <= j_q + 2'd1;
        end
      end
      S_DX: prod_q <= mul_p;
      S_DY: d2_q   <= D2W'(prod_q + mul_p);
      S_CMP, S_WB: begin
        if (!sq_start || (state_q == S_WB)) begin
          if (c_q != 2'd3) begin
            c_q <= c_q + 2'd1;
          end else if (i_q != 2'd2) begin
            i_q <= i_q + 2'd1;
          end else begin
            i_q <= 2'd0;
            j_q <= j_q + 2'd1;
          end
        end
      end
      S_SQRT: begin
        if (sq_done) w_q <= OneQ - (F+1)'(sq_root);
        ch_q <= 2'd0;
      end
      S_K:  k_q    <= mul_p[F+7:0];
      S_CH: prod_q <= mul_p;
      S_ACC: begin
        newc_q[ch_q] <= ch_byte;
        ch_q         <= ch_q + 2'd1;
      end
      S_DONE: begin
        if (out_free) begin
          out_color_q <= res_color_q;
          out_oor_q   <= res_oor_q;
        end
      end
      default: ch_q <= ch_q;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign out_red_o      = out_color_q[31:24];
  assign out_green_o    = out_color_q[23:16];
  assign out_blue_o     = out_color_q[15:8];
  assign out_alpha_o    = out_color_q[7:0];
  assign out_of_range_o = out_oor_q;

`ifndef NO_ASSERTIONS
  // No result may appear while the memory is still being cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !out_valid_q)
    else $error("result during clearing pass");

  // The square root only starts for corners within the brush radius.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_SQRT) && ($past(state_q) == S_CMP)) |-> ($past(d2_q) < D2Limit))
    else $error("square root started outside the radius");

  // The blend weight never exceeds the divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CH) |-> (k_q <= DenVal))
    else $error("blend weight out of range");

  // A write back always targets a cell inside the memory.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WB) |-> (32'(addr_q) < 32'(Depth)))
    else $error("write back address out of range");
`endif

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for radial_brush_vertex_blend: directed and random requests
// against a behavioral predictor of the corner color grid. Depends on rbvb_pkg and the RTL.
`timescale 1ns / 100ps

module tb;

  localparam int Cols = 64;
  localparam int Rows = 64;
  localparam int Frac = 8;
  localparam int LimitCycles = 2_000_000;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       oor;
  } reply_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_index_i = 1'b0;
  logic [6:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] action_i = '0;
  logic [5:0] cell_x_i = '0, cell_y_i = '0;
  logic [1:0] corner_i = '0;
  logic [13:0] brush_x_i = '0, brush_y_i = '0;
  logic [7:0] paint_red_i = '0, paint_green_i = '0, paint_blue_i = '0, paint_alpha_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [7:0] out_red_o, out_green_o, out_blue_o, out_alpha_o;
  logic out_of_range_o;

  radial_brush_vertex_blend i_dut (.*);

  always #10 clk_i = ~clk_i;

  // Predicted grid state and configuration.
  logic [31:0] grid_colors [Cols*Rows*4];
  int unsigned cols_set = 64, rows_set = 64;
  reply_t pending_replies[$];
  int errors = 0;
  int unsigned cycle_count = 0;
  bit long_hold = 1'b0;
  bit burst_mode = 1'b1;

  function automatic int unsigned cols_eff();
    return (cols_set > Cols) ? Cols : cols_set;
  endfunction

  function automatic int unsigned rows_eff();
    return (rows_set > Rows) ? Rows : rows_set;
  endfunction

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned r = 0;
    for (longint unsigned c = 0; c <= 600; c++) if (c * c <= v) r = c;
    return r;
  endfunction

  function automatic logic [31:0] mix(logic [31:0] prev, logic [7:0] r, logic [7:0] g,
                                      logic [7:0] b, longint unsigned k);
    longint unsigned den = 255 << Frac;
    logic [31:0] res = 32'hFF;
    logic [7:0] pc [3];
    pc[0] = r; pc[1] = g; pc[2] = b;
    for (int ch = 0; ch < 3; ch++) begin
      longint unsigned o = (prev >> (24 - 8 * ch)) & 8'hFF;
      longint unsigned n = (o * (den - k) + pc[ch] * k) / den;
      res |= 32'((n & 8'hFF) << (24 - 8 * ch));
    end
    return res;
  endfunction

  // Apply one request to the predicted grid and queue its expected reply.
  function automatic void predict_request(rbvb_pkg::action_e act, int cx, int cy, int cn,
                                          int bx, int by,
                                          logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                          logic [7:0] a);
    reply_t rep = '0;
    bit in_grid = (cx < cols_eff()) && (cy < rows_eff());
    int ox [4] = '{0, 1, 1, 0};
    int oy [4] = '{0, 0, 1, 1};
    case (act)
      rbvb_pkg::ActSet: begin
        if (in_grid) for (int c = 0; c < 4; c++) grid_colors[(cy*Cols+cx)*4+c] = {r, g, b, a};
        else rep.oor = 1'b1;
      end
      rbvb_pkg::ActPaint: begin
        for (int j = -1; j <= 1; j++) begin
          for (int i = -1; i <= 1; i++) begin
            longint y = (by >> Frac) + j;
            longint x = (bx >> Frac) + i;
            if (y < 0 || y >= rows_eff() || x < 0 || x >= cols_eff()) continue;
            for (int c = 0; c < 4; c++) begin
              longint dx = (x + ox[c]) * (1 << Frac) - bx;
              longint dy = (y + oy[c]) * (1 << Frac) - by;
              longint unsigned d2 = dx * dx + dy * dy;
              int idx = int'((y * Cols + x) * 4 + c);
              if (d2 >= (1 << (2 * Frac - 1))) continue;
              grid_colors[idx] = mix(grid_colors[idx], r, g, b,
                                     ((1 << Frac) - isqrt(2 * d2)) * a);
            end
          end
        end
      end
      rbvb_pkg::ActRead: begin
        if (in_grid) {rep.red, rep.green, rep.blue, rep.alpha} = grid_colors[(cy*Cols+cx)*4+cn];
        else rep.oor = 1'b1;
      end
      default: ;
    endcase
    pending_replies.push_back(rep);
  endfunction

  // Send one request; drive at the falling edge, wait for acceptance at the rising edge.
  task automatic send_request(rbvb_pkg::action_e act, int cx, int cy, int cn, int bx, int by,
                              logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
    action_i <= act; cell_x_i <= 6'(cx); cell_y_i <= 6'(cy); corner_i <= 2'(cn);
    brush_x_i <= 14'(bx); brush_y_i <= 14'(by);
    paint_red_i <= r; paint_green_i <= g; paint_blue_i <= b; paint_alpha_i <= a;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    predict_request(act, cx, cy, cn, bx, by, r, g, b, a);
    @(negedge clk_i);
    // Bursts: sometimes leave a gap before the next request, always when burst mode is off.
    if (!burst_mode || $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
  endtask

  task automatic go_idle();
    in_valid_i <= 1'b0;
    while (pending_replies.size() != 0) @(negedge clk_i);
    // Leave some quiet cycles before the next phase.
    repeat (200) @(negedge clk_i);
  endtask

  task automatic write_reg(rbvb_pkg::cfg_index_e idx, int unsigned value);
    cfg_we_i <= 1'b1; cfg_index_i <= idx; cfg_data_i <= 7'(value);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == rbvb_pkg::CfgColumns) cols_set = value; else rows_set = value;
  endtask

  task automatic random_item();
    int sel = $urandom_range(0, 99);
    rbvb_pkg::action_e act = (sel < 25) ? rbvb_pkg::ActSet :
                             (sel < 65) ? rbvb_pkg::ActPaint :
                             (sel < 97) ? rbvb_pkg::ActRead : rbvb_pkg::ActNone;
    int bx = $urandom_range(0, 99) < 85 ? $urandom_range(0, 66 * 256) : $urandom_range(0, 16383);
    int by = $urandom_range(0, 99) < 85 ? $urandom_range(0, 66 * 256) : $urandom_range(0, 16383);
    logic [7:0] a = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom);
    send_request(act, $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 3),
                 bx & 14'h3FFF, by & 14'h3FFF, 8'($urandom), 8'($urandom), 8'($urandom), a);
  endtask

  task automatic test_directed();
    send_request(rbvb_pkg::ActRead, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_request(rbvb_pkg::ActSet, 63, 63, 0, 0, 0, 8'hFF, 8'h00, 8'hFF, 8'h00);
    send_request(rbvb_pkg::ActRead, 63, 63, 3, 0, 0, 0, 0, 0, 0);
    send_request(rbvb_pkg::ActSet, 1, 1, 0, 0, 0, 8'h10, 8'h20, 8'h30, 8'h40);
    // Brush exactly on a grid point, on the low edges and at the far corner.
    send_request(rbvb_pkg::ActPaint, 0, 0, 0, 14'h0100 + 14'h0100, 14'h0100, 0, 0, 0, 255);
    send_request(rbvb_pkg::ActPaint, 0, 0, 0, 14'h0040, 14'h0020, 8'hFF, 8'h80, 8'h00, 200);
    send_request(rbvb_pkg::ActPaint, 0, 0, 0, 14'h3FFF, 14'h3FFF, 8'hAA, 8'h55, 8'h01, 255);
    send_request(rbvb_pkg::ActPaint, 0, 0, 0, 14'h0180, 14'h0180, 8'h00, 8'hFF, 8'h00, 0);
    send_request(rbvb_pkg::ActPaint, 0, 0, 0, 14'h3F00, 14'h0000, 8'h12, 8'h34, 8'h56, 128);
    // Brush on a cell corner: the farthest corners of the 3x3 walk lie two cells away.
    send_request(rbvb_pkg::ActPaint, 0, 0, 0, 14'h0500, 14'h0500, 8'h01, 8'h02, 8'h03, 255);
    for (int c = 0; c < 4; c++) send_request(rbvb_pkg::ActRead, 1, 1, c, 0, 0, 0, 0, 0, 0);
    send_request(rbvb_pkg::ActRead, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_request(rbvb_pkg::ActRead, 5, 5, 2, 0, 0, 0, 0, 0, 0);
    send_request(rbvb_pkg::ActRead, 6, 6, 2, 0, 0, 0, 0, 0, 0);
    send_request(rbvb_pkg::ActNone, 63, 63, 3, 14'h3FFF, 14'h3FFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_request(rbvb_pkg::ActRead, 2, 0, 3, 0, 0, 0, 0, 0, 0);
    go_idle();
  endtask

  task automatic test_small_grid();
    write_reg(rbvb_pkg::CfgColumns, 1);
    write_reg(rbvb_pkg::CfgRows, 1);
    send_request(rbvb_pkg::ActSet, 1, 0, 0, 0, 0, 1, 2, 3, 4);
    send_request(rbvb_pkg::ActSet, 0, 1, 0, 0, 0, 1, 2, 3, 4);
    send_request(rbvb_pkg::ActRead, 1, 1, 2, 0, 0, 0, 0, 0, 0);
    send_request(rbvb_pkg::ActPaint, 0, 0, 0, 14'h0100, 14'h0100, 8'h00, 8'h00, 8'hFF, 255);
    for (int n = 0; n < 150; n++) random_item();
    go_idle();
    // Values above the grid size count as the full grid; zero disables it.
    write_reg(rbvb_pkg::CfgColumns, 127);
    write_reg(rbvb_pkg::CfgRows, 0);
    for (int n = 0; n < 100; n++) random_item();
    go_idle();
    write_reg(rbvb_pkg::CfgColumns, $urandom_range(2, 63));
    write_reg(rbvb_pkg::CfgRows, $urandom_range(2, 63));
    for (int n = 0; n < 300; n++) random_item();
    go_idle();
    write_reg(rbvb_pkg::CfgColumns, 64);
    write_reg(rbvb_pkg::CfgRows, 64);
  endtask

  task automatic test_backpressure();
    burst_mode = 1'b0;
    long_hold = 1'b1;
    for (int n = 0; n < 40; n++) random_item();
    burst_mode = 1'b1;
    go_idle();
  endtask

  task automatic test_random();
    // Focus on a few cells so paints and reads overlap.
    for (int n = 0; n < 1350; n++) begin
      if (n % 3 == 0)
        send_request(rbvb_pkg::ActRead, $urandom_range(0, 5), $urandom_range(0, 5),
                     $urandom_range(0, 3), 0, 0, 0, 0, 0, 0);
      else if (n % 3 == 1)
        send_request(rbvb_pkg::ActPaint, 0, 0, 0, $urandom_range(0, 6 * 256),
                     $urandom_range(0, 6 * 256),
                     8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      else random_item();
    end
    go_idle();
  endtask

  // Receiver stall pattern, with one long hold-off when requested.
  always @(negedge clk_i) begin
    if (long_hold) begin
      out_stall_i <= 1'b1;
      repeat (3000) @(negedge clk_i);
      long_hold = 1'b0;
      out_stall_i <= 1'b0;
    end else if (cycle_count % 4000 < 1500) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 3) == 0);
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    reply_t got, exp_rep;
    cycle_count <= cycle_count + 1;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {out_red_o, out_green_o, out_blue_o, out_alpha_o, out_of_range_o};
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $realtime, got);
        errors++;
      end else begin
        exp_rep = pending_replies.pop_front();
        if (got != exp_rep) begin
          $display("%0t: mismatch, expected r%h g%h b%h a%h oor%b, actual r%h g%h b%h a%h oor%b",
                   $realtime, exp_rep.red, exp_rep.green, exp_rep.blue, exp_rep.alpha,
                   exp_rep.oor, got.red, got.green, got.blue, got.alpha, got.oor);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycle_count >= LimitCycles) begin
      $display("** radial_brush_vertex_blend: FAILED **");
      $finish;
    end
  end

  initial begin
    for (int n = 0; n < Cols * Rows * 4; n++) grid_colors[n] = 32'hFFFF_FFFF;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_small_grid();
    test_backpressure();
    test_random();
    if (pending_replies.size() != 0) errors++;
    if (errors == 0) begin
      $display("** radial_brush_vertex_blend: PASSED **");
    end else begin
      $display("** radial_brush_vertex_blend: FAILED **");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
hw/rtl/rbvb_pkg.sv
hw/rtl/rbvb_isqrt.sv
hw/rtl/radial_brush_vertex_blend.sv
tb/tb.sv
